FILE: hw/rtl/itcf_pkg.sv
package itcf_pkg;

  // field widths
  localparam int SampleW   = 16;
  localparam int AngleOutW = 13;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int CalCountW = 7;

  // internal widths
  localparam int AngW   = 25;  // q16 angles, rates and offsets
  localparam int SumW   = 32;  // calibration sums
  localparam int DivW   = 32;  // divider dividend magnitude
  localparam int DivCntW = 2;
  localparam int SqrtRadW = 48;
  localparam int SqrtRootW = 24;
  localparam int SqrtRemW = 25;
  localparam int SqrtCntW = 5;
  localparam int CordW  = 28;
  localparam int ZW     = 27;
  localparam int AtanW  = 23;

  // parameter defaults
  localparam int CalSamplesDef  = 100;
  localparam int CordicStepsDef = 20;

  // constants
  localparam logic [7:0] RateDivisor = 8'd131;
  localparam logic [ZW-1:0] Deg90  = ZW'(90 << 16);
  localparam logic [ZW-1:0] Deg180 = ZW'(180 << 16);
  localparam int SatOut = 3600;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgGyroWeight = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStepTime   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDeadband   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgUnmapped   = 2'd3;

  // register reset values
  localparam logic [15:0] GyroWeightRst = 16'd58982;
  localparam logic [15:0] StepTimeRst   = 16'd1376;
  localparam logic [6:0]  DeadbandRst   = 7'd15;

  // divider operand select
  typedef enum logic [1:0] {
    DivRate,
    DivGyroSum,
    DivAccelSum
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     square;
    logic     msum;
    logic     acc_direct;
    logic     sqrt_start;
    logic     cordic_init;
    logic     cordic_step;
    logic     acc_clamp;
    logic     div_start;
    div_sel_e div_sel;
    logic     rate_store;
    logic     cal_acc;
    logic     goff_store;
    logic     aoff_store;
    logic     f_rate;
    logic     f_gyro;
    logic     f_mul_g;
    logic     f_mul_a;
    logic     f_sum;
    logic     out_load;
  } itcf_cmd_t;

  typedef struct packed {
    logic direct;
    logic sqrt_busy;
    logic cord_last;
    logic div_busy;
    logic out_free;
  } itcf_status_t;

  // atan(2^-i) in degrees, q16
  function automatic logic [AtanW-1:0] atan_lut(input logic [4:0] i);
    logic [AtanW-1:0] v;
    unique case (i)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/itcf_if.sv
interface itcf_in_if;
  import itcf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SampleW-1:0]  gyro_raw;
  logic signed [SampleW-1:0]  accel_x_raw;
  logic signed [SampleW-1:0]  accel_y_raw;
  logic signed [SampleW-1:0]  accel_z_raw;
  modport source (output valid, gyro_raw, accel_x_raw, accel_y_raw, accel_z_raw,
                  input ready);
  modport sink (input valid, gyro_raw, accel_x_raw, accel_y_raw, accel_z_raw,
                output ready);
endinterface

interface itcf_out_if;
  import itcf_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [AngleOutW-1:0]  angle_tenths;
  modport source (output valid, angle_tenths, input ready);
  modport sink (input valid, angle_tenths, output ready);
endinterface

interface itcf_cfg_if;
  import itcf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/itcf_ctrl.sv
module itcf_ctrl import itcf_pkg::*; #(
  parameter int CAL_SAMPLES = CalSamplesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  itcf_status_t status_i,
  output itcf_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    StIdle, StSquare, StMsum, StCheck, StSqrt, StCordic, StClamp, StWaitDiv,
    StCalAcc, StDivGGo, StDivGWait, StDivAGo, StDivAWait,
    StFRate, StFGyro, StFMulG, StFMulA, StFSum, StOut
  } state_e;

  state_e state_q, state_d;
  logic [CalCountW-1:0] cal_cnt_q, cal_cnt_d;

  assign in_ready_o = (state_q == StIdle);

  // next state and commands
  always_comb begin
    state_d   = state_q;
    cal_cnt_d = cal_cnt_q;
    cmd_o     = '0;
    cmd_o.div_sel = DivRate;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StSquare;
        end
      end
      StSquare: begin
        cmd_o.square    = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DivRate;
        state_d = StMsum;
      end
      StMsum: begin
        cmd_o.msum = 1'b1;
        state_d = StCheck;
      end
      StCheck: begin
        if (status_i.direct) begin
          cmd_o.acc_direct = 1'b1;
          state_d = StWaitDiv;
        end else begin
          cmd_o.sqrt_start = 1'b1;
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        if (!status_i.sqrt_busy) begin
          cmd_o.cordic_init = 1'b1;
          state_d = StCordic;
        end
      end
      StCordic: begin
        cmd_o.cordic_step = 1'b1;
        if (status_i.cord_last) state_d = StClamp;
      end
      StClamp: begin
        cmd_o.acc_clamp = 1'b1;
        state_d = StWaitDiv;
      end
      StWaitDiv: begin
        if (!status_i.div_busy) begin
          cmd_o.rate_store = 1'b1;
          if (cal_cnt_q < CalCountW'(CAL_SAMPLES)) state_d = StCalAcc;
          else state_d = StFRate;
        end
      end
      StCalAcc: begin
        cmd_o.cal_acc = 1'b1;
        cal_cnt_d = cal_cnt_q + 1'b1;
        if (cal_cnt_q == CalCountW'(CAL_SAMPLES - 1)) state_d = StDivGGo;
        else state_d = StIdle;
      end
      StDivGGo: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DivGyroSum;
        state_d = StDivGWait;
      end
      StDivGWait: begin
        if (!status_i.div_busy) begin
          cmd_o.goff_store = 1'b1;
          state_d = StDivAGo;
        end
      end
      StDivAGo: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DivAccelSum;
        state_d = StDivAWait;
      end
      StDivAWait: begin
        if (!status_i.div_busy) begin
          cmd_o.aoff_store = 1'b1;
          state_d = StIdle;
        end
      end
      StFRate: begin
        cmd_o.f_rate = 1'b1;
        state_d = StFGyro;
      end
      StFGyro: begin
        cmd_o.f_gyro = 1'b1;
        state_d = StFMulG;
      end
      StFMulG: begin
        cmd_o.f_mul_g = 1'b1;
        state_d = StFMulA;
      end
      StFMulA: begin
        cmd_o.f_mul_a = 1'b1;
        state_d = StFSum;
      end
      StFSum: begin
        cmd_o.f_sum = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state and calibration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cal_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      cal_cnt_q <= cal_cnt_d;
    end
  end

endmodule

FILE: hw/rtl/itcf_datapath.sv
module itcf_datapath import itcf_pkg::*; #(
  parameter int CAL_SAMPLES  = CalSamplesDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  itcf_cmd_t                   cmd_i,
  output itcf_status_t                status_o,
  input  logic signed [SampleW-1:0]   gyro_raw_i,
  input  logic signed [SampleW-1:0]   accel_x_raw_i,
  input  logic signed [SampleW-1:0]   accel_y_raw_i,
  input  logic signed [SampleW-1:0]   accel_z_raw_i,
  input  logic [15:0]                 gyro_weight_i,
  input  logic [15:0]                 step_time_i,
  input  logic [6:0]                  deadband_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [AngleOutW-1:0] angle_tenths_o
);

  localparam int CntW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // input samples
  logic signed [SampleW-1:0] gyro_q, ax_q, ay_q, az_q;
  // squares and magnitude
  logic [31:0] sx_q, sy_q, sz_q, m_q;
  // accel angle and rate
  logic signed [AngW-1:0] acc_q, rate_q, goff_q, aoff_q;
  logic signed [SumW-1:0] gsum_q, asum_q;
  // filter pipeline
  logic signed [42:0] p1_q;
  logic signed [32:0] g_q;
  logic signed [49:0] m1_q;
  logic signed [43:0] m2_q;
  logic signed [31:0] prev_q;
  // output register
  logic                        out_valid_q;
  logic signed [AngleOutW-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      gyro_q <= gyro_raw_i;
      ax_q   <= accel_x_raw_i;
      ay_q   <= accel_y_raw_i;
      az_q   <= accel_z_raw_i;
    end
    if (cmd_i.square) begin
      sx_q <= 32'(ax_q * ax_q);
      sy_q <= 32'(ay_q * ay_q);
      sz_q <= 32'(az_q * az_q);
    end
    if (cmd_i.msum) m_q <= sy_q + sz_q;
  end

  assign status_o.direct = (ax_q == '0) || (sx_q >= m_q);

  // integer square root, two radicand bits per cycle
  logic [SqrtRadW-1:0]  sq_rad_q;
  logic [SqrtRootW-1:0] sq_root_q;
  logic [SqrtRemW-1:0]  sq_rem_q;
  logic [SqrtCntW-1:0]  sq_cnt_q;
  logic                 sq_busy_q;
  logic [SqrtRemW+1:0]  sq_rem_t, sq_trial;
  logic                 sq_ge;

  assign sq_rem_t = {sq_rem_q, sq_rad_q[SqrtRadW-1 -: 2]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};
  assign sq_ge    = (sq_rem_t >= sq_trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else if (cmd_i.sqrt_start) begin
      sq_busy_q <= 1'b1;
      sq_cnt_q  <= '0;
    end else if (sq_busy_q) begin
      sq_cnt_q <= sq_cnt_q + 1'b1;
      if (sq_cnt_q == SqrtCntW'(SqrtRootW - 1)) sq_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sq_rad_q  <= {m_q - sx_q, 16'h0};
      sq_root_q <= '0;
      sq_rem_q  <= '0;
    end else if (sq_busy_q) begin
      sq_rad_q  <= {sq_rad_q[SqrtRadW-3:0], 2'b00};
      sq_root_q <= {sq_root_q[SqrtRootW-2:0], sq_ge};
      sq_rem_q  <= sq_ge ? SqrtRemW'(sq_rem_t - sq_trial) : SqrtRemW'(sq_rem_t);
    end
  end

  assign status_o.sqrt_busy = sq_busy_q;

  // cordic vectoring, one rotation per cycle
  logic signed [CordW-1:0] cx_q, cy_q, ax256, cdx, cdy;
  logic signed [ZW-1:0]    cz_q, catan;
  logic [CntW-1:0]         ccnt_q;

  assign ax256 = {{(CordW-SampleW-8){ax_q[SampleW-1]}}, ax_q, 8'h00};
  assign cdx   = cy_q >>> ccnt_q;
  assign cdy   = cx_q >>> ccnt_q;
  assign catan = $signed({{(ZW-AtanW){1'b0}}, atan_lut(5'(ccnt_q))});
  assign status_o.cord_last = (ccnt_q == CntW'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_init) begin
      ccnt_q <= '0;
      if (ax_q[SampleW-1]) begin
        cx_q <= $signed({{(CordW-SqrtRootW){1'b0}}, sq_root_q});
        cy_q <= -ax256;
        cz_q <= $signed(Deg90);
      end else begin
        cx_q <= ax256;
        cy_q <= $signed({{(CordW-SqrtRootW){1'b0}}, sq_root_q});
        cz_q <= '0;
      end
    end else if (cmd_i.cordic_step) begin
      ccnt_q <= ccnt_q + 1'b1;
      if (cy_q > 0) begin
        cx_q <= cx_q + cdx;
        cy_q <= cy_q - cdy;
        cz_q <= cz_q + catan;
      end else begin
        cx_q <= cx_q - cdx;
        cy_q <= cy_q + cdy;
        cz_q <= cz_q - catan;
      end
    end
  end

  // accel angle, direct cases or clamped cordic angle
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_direct) begin
      if (ax_q == '0) acc_q <= AngW'($signed(Deg90));
      else if (ax_q > 0) acc_q <= '0;
      else acc_q <= AngW'($signed(Deg180));
    end else if (cmd_i.acc_clamp) begin
      if (cz_q < 0) acc_q <= '0;
      else if (cz_q > $signed(Deg180)) acc_q <= AngW'($signed(Deg180));
      else acc_q <= AngW'(cz_q);
    end
  end

  // reciprocal divider by a small constant, truncates toward zero
  // the product estimate is at most one low, one compare fixes it
  localparam logic [DivW:0] RateRecip = (DivW+1)'((64'd1 << DivW) / RateDivisor);
  localparam logic [DivW:0] CalRecip  = (DivW+1)'((64'd1 << DivW) / CAL_SAMPLES);

  logic [7:0]             div_den_q;
  logic [DivW:0]          div_m_q;
  logic [DivW-1:0]        div_n_q, div_q_q;
  logic [8:0]             div_r_q;
  logic [DivCntW-1:0]     div_cnt_q;
  logic                   div_neg_q, div_busy_q;
  logic signed [DivW-1:0] div_src;
  logic [2*DivW:0]        div_prod;
  logic signed [DivW-1:0] div_res;

  always_comb begin
    case (cmd_i.div_sel)
      DivGyroSum:  div_src = gsum_q;
      DivAccelSum: div_src = asum_q;
      default:     div_src = {gyro_q, 16'h0};
    endcase
  end

  assign div_prod = div_n_q * div_m_q;
  assign div_res  = div_neg_q ? -$signed(div_q_q) : $signed(div_q_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + 1'b1;
      if (div_cnt_q == DivCntW'(2)) div_busy_q <= 1'b0;
    end
  end

  // estimate, remainder, then correction
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_neg_q <= div_src[DivW-1];
      div_n_q   <= div_src[DivW-1] ? DivW'(-div_src) : DivW'(div_src);
      div_den_q <= (cmd_i.div_sel == DivRate) ? RateDivisor : 8'(CAL_SAMPLES);
      div_m_q   <= (cmd_i.div_sel == DivRate) ? RateRecip : CalRecip;
    end else if (div_busy_q) begin
      case (div_cnt_q)
        2'd0: div_q_q <= DivW'(div_prod >> DivW);
        2'd1: div_r_q <= 9'(div_n_q - DivW'(div_q_q * div_den_q));
        default: begin
          if (div_r_q >= {1'b0, div_den_q}) div_q_q <= div_q_q + 1'b1;
        end
      endcase
    end
  end

  assign status_o.div_busy = div_busy_q;

  // rate, calibration sums and offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsum_q <= '0;
      asum_q <= '0;
      goff_q <= '0;
      aoff_q <= '0;
    end else begin
      if (cmd_i.cal_acc) begin
        gsum_q <= gsum_q + SumW'(rate_q);
        asum_q <= asum_q + SumW'(acc_q);
      end
      if (cmd_i.goff_store) goff_q <= AngW'(div_res);
      if (cmd_i.aoff_store) aoff_q <= AngW'(div_res);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rate_store) rate_q <= AngW'(div_res);
  end

  // complementary filter steps
  logic signed [AngW:0]  d_rate, d_acc;
  logic signed [17:0]    wa;
  logic signed [50:0]    fsum, fsh;

  assign d_rate = (AngW+1)'(rate_q) - (AngW+1)'(goff_q);
  assign d_acc  = (AngW+1)'(acc_q) - (AngW+1)'(aoff_q);
  assign wa     = $signed(18'(17'h10000 - {1'b0, gyro_weight_i}));
  assign fsum   = 51'(m1_q) + 51'(m2_q);
  assign fsh    = fsum >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (cmd_i.f_sum) begin
      if (fsh > 51'sd2147483647) prev_q <= 32'sh7fffffff;
      else if (fsh < -51'sd2147483648) prev_q <= 32'sh80000000;
      else prev_q <= 32'(fsh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.f_rate) p1_q <= d_rate * $signed({1'b0, step_time_i});
    if (cmd_i.f_gyro) g_q <= 33'(prev_q) + 33'(p1_q >>> 16);
    if (cmd_i.f_mul_g) m1_q <= g_q * $signed({1'b0, gyro_weight_i});
    if (cmd_i.f_mul_a) m2_q <= 44'(d_acc * wa);
  end

  // tenths, deadband and saturation
  logic signed [35:0] p10, p10r;
  logic signed [19:0] tt, db, tout;

  assign p10  = (36'(prev_q) <<< 3) + (36'(prev_q) <<< 1);
  assign p10r = p10 + (p10[35] ? 36'sd65535 : 36'sd0);
  assign tt   = 20'(p10r >>> 16);
  assign db   = $signed({13'h0, deadband_i});

  always_comb begin
    tout = tt;
    if (tt < db && tt > -db) tout = '0;
    if (tout > 20'(SatOut)) tout = 20'(SatOut);
    if (tout < -20'(SatOut)) tout = -20'(SatOut);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_data_q <= AngleOutW'(tout);
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign angle_tenths_o    = out_data_q;

endmodule

FILE: hw/rtl/imu_tilt_complementary_filter.sv
// Tilt angle from one gyro axis and a three-axis accelerometer.
// in_i takes one transaction per sample set: gyro_raw and accel x/y/z, all
// signed 16 bit. out_o carries angle_tenths, signed tenths of a degree.
// cfg_i writes gyro_weight (0), step_time (1) and deadband_tenths (2); other
// indexes are ignored. Writes are taken in any cycle, ready is always high.
// The first CAL_SAMPLES inputs give no output; they build the gyro and accel
// offsets. Every later input gives exactly one output.
// One sample set is worked on at a time. From input to output it passes
// through the squares, the square root, CORDIC_STEPS rotations, then five
// filter steps and the output load. The gyro rate uses a reciprocal divide
// that runs alongside. When x alone sets the accel angle there is no root
// or rotation. The next input is accepted in the cycle after the output
// load. The last calibration input also runs the two offset divides.
// The result sits in an output register; the next sample is accepted while
// it waits. A stalled receiver holds the next result in its final step until
// the register frees up.
// Reset restores the default registers and restarts calibration.
module imu_tilt_complementary_filter import itcf_pkg::*; #(
  parameter int CAL_SAMPLES  = CalSamplesDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itcf_in_if.sink     in_i,
  itcf_out_if.source  out_o,
  itcf_cfg_if.sink    cfg_i
);

  logic [15:0] gyro_weight_q, step_time_q;
  logic [6:0]  deadband_q;
  itcf_cmd_t    cmd;
  itcf_status_t status;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_weight_q <= GyroWeightRst;
      step_time_q   <= StepTimeRst;
      deadband_q    <= DeadbandRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgGyroWeight: gyro_weight_q <= cfg_i.data;
        CfgStepTime:   step_time_q   <= cfg_i.data;
        CfgDeadband:   deadband_q    <= cfg_i.data[6:0];
        default: ;
      endcase
    end
  end

  itcf_ctrl #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itcf_datapath #(
    .CAL_SAMPLES  (CAL_SAMPLES),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .gyro_raw_i     (in_i.gyro_raw),
    .accel_x_raw_i  (in_i.accel_x_raw),
    .accel_y_raw_i  (in_i.accel_y_raw),
    .accel_z_raw_i  (in_i.accel_z_raw),
    .gyro_weight_i  (gyro_weight_q),
    .step_time_i    (step_time_q),
    .deadband_i     (deadband_q),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .angle_tenths_o (out_o.angle_tenths)
  );

endmodule
